// File: sv/dhl_pkg.sv
// ----------------------------------------------------------------------------
// dhl_pkg: shared constants for the double hash label table
// Field widths and action codes used by the table and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package dhl_pkg;

	localparam int KEY_W  = 31;
	localparam int SLOT_W = 10;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

endpackage

`default_nettype wire

// File: sv/dhl_ram.sv
// ----------------------------------------------------------------------------
// dhl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dhl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/dhl_div.sv
// ----------------------------------------------------------------------------
// dhl_div: divider by a fixed divisor using reciprocal multiplication
// One shared multiplier for the reciprocal and back-multiply phases; done pulses when quotient and
// remainder hold.
// ----------------------------------------------------------------------------
`default_nettype none

module dhl_div #(
	parameter int DIVISOR = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [dhl_pkg::KEY_W-1:0]  dividend,
	output logic                            done,
	output logic      [dhl_pkg::KEY_W-1:0]  quot,
	output logic      [$clog2(DIVISOR)-1:0] rem
);

	import dhl_pkg::*;

	localparam int RW = $clog2(DIVISOR);
	localparam int MW = 32;
	localparam int PW = KEY_W + MW;
	// ceil(2^(KEY_W+RW) / DIVISOR): exact quotient for every KEY_W-bit dividend
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << (KEY_W + RW)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_WIDE);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_RECIP = 4'b0010,
		PH_BACK  = 4'b0100,
		PH_SUB   = 4'b1000
	} phase_t;

	phase_t           phase_q;
	logic             done_q;
	logic [KEY_W-1:0] work_q;
	logic [KEY_W-1:0] quot_q;
	logic [PW-1:0]    prod_q;
	logic [RW-1:0]    rem_q;

	logic [KEY_W-1:0] quot_est;
	logic [KEY_W-1:0] mul_a;
	logic [MW-1:0]    mul_b;
	logic [PW-1:0]    mul_p;

	assign quot_est = KEY_W'(prod_q >> (KEY_W + RW));
	assign mul_a    = (phase_q == PH_RECIP) ? work_q : quot_est;
	assign mul_b    = (phase_q == PH_RECIP) ? RECIP : MW'(DIVISOR);
	assign mul_p    = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_SUB);
			if (start) begin
				phase_q <= PH_RECIP;
			end else begin
				unique case (phase_q)
					PH_IDLE:  phase_q <= PH_IDLE;
					PH_RECIP: phase_q <= PH_BACK;
					PH_BACK:  phase_q <= PH_SUB;
					PH_SUB:   phase_q <= PH_IDLE;
					default:  phase_q <= PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
		end
		if ((phase_q == PH_RECIP) || (phase_q == PH_BACK)) begin
			prod_q <= mul_p;
		end
		if (phase_q == PH_BACK) begin
			quot_q <= quot_est;
		end
		if (phase_q == PH_SUB) begin
			rem_q <= work_q[RW-1:0] - prod_q[RW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: sv/double_hash_label_table.sv
// ----------------------------------------------------------------------------
// double_hash_label_table: open-addressing key table with double hashing
// First probe is key mod TABLE_SIZE, step is (key / TABLE_SIZE) mod TABLE_SIZE (1 if key / TABLE_SIZE is zero).
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid/req_ready  | action, key
//  rsp     | rsp_valid/rsp_ready  | slot, overflow
//
//  After reset a clearing pass writes every slot, with req_ready low.
//  A result follows its request beat through two passes of the shared divider, then one
//  RAM read and one compare per probe, and one write. Overflow skips the write. One item
//  at a time; req_ready is high only when idle, from the cycle after the result is loaded.
//  A result waiting on rsp_ready holds the block before its next result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_label_table #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire logic                       action,
	input  wire logic [dhl_pkg::KEY_W-1:0]  key,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output logic      [dhl_pkg::SLOT_W-1:0] slot,
	output logic                            overflow
);

	import dhl_pkg::*;

	localparam int SW = $clog2(TABLE_SIZE);
	localparam int DW = KEY_W + 1;

	typedef enum logic [7:0] {
		ST_CLR  = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_DIV1 = 8'b0000_0100,
		ST_DIV2 = 8'b0000_1000,
		ST_RD   = 8'b0001_0000,
		ST_CHK  = 8'b0010_0000,
		ST_WR   = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic [SW-1:0]    clr_ptr_q;
	logic [SW-1:0]    pos_q;
	logic [SW-1:0]    step_q;
	logic [SW-1:0]    cnt_q;
	logic             zero_q;
	logic             ovf_q;
	action_t          act_q;
	logic [KEY_W-1:0] key_q;
	logic             rsp_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic             overflow_q;

	logic             div_start;
	logic [KEY_W-1:0] div_dividend;
	logic             div_done;
	logic [KEY_W-1:0] div_quot;
	logic [SW-1:0]    div_rem;

	logic             ram_wr_en;
	logic [SW-1:0]    ram_wr_addr;
	logic [DW-1:0]    ram_wr_data;
	logic             ram_rd_en;
	logic [DW-1:0]    ram_rd_data;

	logic             req_beat;
	logic             out_load;
	logic             hit;
	logic [SW:0]      pos_sum;
	logic [SW-1:0]    pos_next;

	assign req_ready = (state_q == ST_IDLE);
	assign req_beat  = req_valid && req_ready;
	assign out_load  = (state_q == ST_OUT) && (!rsp_valid_q || rsp_ready);

	assign div_start    = req_beat || ((state_q == ST_DIV1) && div_done);
	assign div_dividend = req_beat ? key : div_quot;

	dhl_div #(
		.DIVISOR (TABLE_SIZE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = pos_q;
		ram_wr_data = '0;
		if (state_q == ST_CLR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_ptr_q;
		end else if (state_q == ST_WR) begin
			ram_wr_en   = 1'b1;
			ram_wr_data = {act_q == ACT_INSERT, key_q};
		end
	end

	assign ram_rd_en = (state_q == ST_RD);

	dhl_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (pos_q),
		.rd_data (ram_rd_data)
	);

	assign hit      = !ram_rd_data[KEY_W] || (ram_rd_data[KEY_W-1:0] == key_q);
	assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_next = (pos_sum >= (SW+1)'(TABLE_SIZE)) ?
	                  SW'(pos_sum - (SW+1)'(TABLE_SIZE)) : pos_sum[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_ptr_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_ptr_q <= clr_ptr_q + SW'(1);
					if (clr_ptr_q == SW'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_beat) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (hit) begin
						state_q <= ST_WR;
					end else if (cnt_q == SW'(TABLE_SIZE - 1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			act_q <= action_t'(action);
			key_q <= key;
			ovf_q <= 1'b0;
		end
		if ((state_q == ST_DIV1) && div_done) begin
			pos_q  <= div_rem;
			zero_q <= (div_quot == '0);
		end
		if ((state_q == ST_DIV2) && div_done) begin
			step_q <= zero_q ? SW'(1) : div_rem;
			cnt_q  <= '0;
		end
		if ((state_q == ST_CHK) && !hit) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + SW'(1);
			if (cnt_q == SW'(TABLE_SIZE - 1)) begin
				ovf_q <= 1'b1;
			end
		end
		if (out_load) begin
			slot_q     <= ovf_q ? '0 : SLOT_W'(pos_q);
			overflow_q <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign slot      = slot_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire
